### rtl/core/rdw_pkg.sv
// Shared types and constants of the rational drive waveshaper.
`timescale 1ns / 1ps

package rdw_pkg;

    localparam int DRIVE_BITS = 16;
    localparam logic [DRIVE_BITS-1:0] DRIVE_RESET = 16'd256;
    localparam int DRIVE_ONE = 256;

    typedef struct packed {
        logic neg;
        logic channel;
        logic buffer_end;
    } rdw_side_t;

endpackage

### rtl/core/rational_drive_waveshaper.sv
// Rational drive waveshaper top level: sign(x)*(d+1)|x|/(1+d|x|) on a sample stream.
// Input channel s_*: one sample word per cycle with its channel tag and buffer-end mark,
// taken when s_valid and s_ready are both high. Output channel m_*: the shaped sample,
// the same tag and mark, handed over when m_valid and m_ready are both high.
// cfg_wr_en with cfg_wr_data loads the Q8.8 drive; write it only while the block is idle.
// Stages from acceptance to m_valid: magnitude, drive product, numerator/denominator,
// one restoring divider step per quotient bit, round/saturate, output register.
// Throughput is one word per cycle while no skid word is pending; the divider is
// fully unrolled into stages.
// When the receiver stalls, the output register holds and one more word lands in a
// skid register; the pipeline and s_ready then freeze until the skid word drains.
// Synchronous reset clears every valid bit, empties the skid slot and sets the
// drive to 1.0; s_ready is high in the first cycle after reset.
`timescale 1ns / 1ps

module rational_drive_waveshaper #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [rdw_pkg::DRIVE_BITS-1:0]     cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [SAMPLE_BITS-1:0]      s_sample_in,
    input  logic                               s_channel_in,
    input  logic                               s_buffer_end_in,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [SAMPLE_BITS-1:0]      m_sample_out,
    output logic                               m_channel_out,
    output logic                               m_buffer_end_out
);
    import rdw_pkg::*;

    localparam int DW = SAMPLE_BITS + DRIVE_BITS;

    logic [DRIVE_BITS-1:0]  drive_reg;
    logic                   en;

    logic                   div_valid [0:SAMPLE_BITS];
    rdw_side_t              div_side  [0:SAMPLE_BITS];
    logic [DW-1:0]          div_rem   [0:SAMPLE_BITS];
    logic [DW-1:0]          div_den   [0:SAMPLE_BITS];
    logic [SAMPLE_BITS-1:0] div_quo   [0:SAMPLE_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_reg <= DRIVE_RESET;
        end else if (cfg_wr_en) begin
            drive_reg <= cfg_wr_data;
        end
    end

    assign s_ready = en;

    rdw_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .in_valid      (s_valid),
        .in_sample     (s_sample_in),
        .in_channel    (s_channel_in),
        .in_buffer_end (s_buffer_end_in),
        .drive         (drive_reg),
        .out_valid     (div_valid[0]),
        .out_side      (div_side[0]),
        .out_num       (div_rem[0]),
        .out_den       (div_den[0])
    );

    assign div_quo[0] = '0;

    for (genvar i = 0; i < SAMPLE_BITS; i++) begin : g_div
        rdw_div_step #(.SAMPLE_BITS(SAMPLE_BITS)) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (div_valid[i]),
            .in_side   (div_side[i]),
            .in_rem    (div_rem[i]),
            .in_den    (div_den[i]),
            .in_quo    (div_quo[i]),
            .out_valid (div_valid[i+1]),
            .out_side  (div_side[i+1]),
            .out_rem   (div_rem[i+1]),
            .out_den   (div_den[i+1]),
            .out_quo   (div_quo[i+1])
        );
    end

    rdw_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .en               (en),
        .in_valid         (div_valid[SAMPLE_BITS]),
        .in_side          (div_side[SAMPLE_BITS]),
        .in_quo           (div_quo[SAMPLE_BITS]),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_sample_out     (m_sample_out),
        .m_channel_out    (m_channel_out),
        .m_buffer_end_out (m_buffer_end_out)
    );

endmodule

### rtl/core/rdw_front.sv
// Front stages: sample magnitude, drive product, numerator and denominator.
`timescale 1ns / 1ps

module rdw_front #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic signed [SAMPLE_BITS-1:0]         in_sample,
    input  logic                                  in_channel,
    input  logic                                  in_buffer_end,
    input  logic [rdw_pkg::DRIVE_BITS-1:0]        drive,
    output logic                                  out_valid,
    output rdw_pkg::rdw_side_t                    out_side,
    output logic [SAMPLE_BITS+rdw_pkg::DRIVE_BITS-1:0] out_num,
    output logic [SAMPLE_BITS+rdw_pkg::DRIVE_BITS-1:0] out_den
);
    import rdw_pkg::*;

    localparam int DW = SAMPLE_BITS + DRIVE_BITS;

    logic [SAMPLE_BITS-1:0] raw;
    logic [SAMPLE_BITS-1:0] mag_next;
    rdw_side_t              side_next;

    logic                   s1_valid_reg;
    rdw_side_t              s1_side_reg;
    logic [SAMPLE_BITS-1:0] s1_mag_reg;

    logic                   s2_valid_reg;
    rdw_side_t              s2_side_reg;
    logic [SAMPLE_BITS-1:0] s2_mag_reg;
    logic [DW-1:0]          s2_prod_reg;

    logic                   s3_valid_reg;
    rdw_side_t              s3_side_reg;
    logic [DW-1:0]          s3_num_reg;
    logic [DW-1:0]          s3_den_reg;

    always_comb begin
        raw = in_sample;
        mag_next = raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;
        side_next.neg = raw[SAMPLE_BITS-1];
        side_next.channel = in_channel;
        side_next.buffer_end = in_buffer_end;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_side_reg <= side_next;
            s1_mag_reg  <= mag_next;
            s2_side_reg <= s1_side_reg;
            s2_mag_reg  <= s1_mag_reg;
            s2_prod_reg <= DW'(drive) * DW'(s1_mag_reg);
            s3_side_reg <= s2_side_reg;
            s3_num_reg  <= s2_prod_reg + (DW'(s2_mag_reg) << 8);
            s3_den_reg  <= s2_prod_reg + (DW'(DRIVE_ONE) << (SAMPLE_BITS - 1));
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_side  = s3_side_reg;
    assign out_num   = s3_num_reg;
    assign out_den   = s3_den_reg;

endmodule

### rtl/core/rdw_div_step.sv
// One restoring division step: shift, compare, subtract, emit a quotient bit.
`timescale 1ns / 1ps

module rdw_div_step #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       en,
    input  logic                                       in_valid,
    input  rdw_pkg::rdw_side_t                         in_side,
    input  logic [SAMPLE_BITS+rdw_pkg::DRIVE_BITS-1:0] in_rem,
    input  logic [SAMPLE_BITS+rdw_pkg::DRIVE_BITS-1:0] in_den,
    input  logic [SAMPLE_BITS-1:0]                     in_quo,
    output logic                                       out_valid,
    output rdw_pkg::rdw_side_t                         out_side,
    output logic [SAMPLE_BITS+rdw_pkg::DRIVE_BITS-1:0] out_rem,
    output logic [SAMPLE_BITS+rdw_pkg::DRIVE_BITS-1:0] out_den,
    output logic [SAMPLE_BITS-1:0]                     out_quo
);
    import rdw_pkg::*;

    localparam int DW = SAMPLE_BITS + DRIVE_BITS;

    logic [DW:0]            trial;
    logic [DW:0]            diff;
    logic                   take;
    logic [DW-1:0]          rem_next;

    logic                   valid_reg;
    rdw_side_t              side_reg;
    logic [DW-1:0]          rem_reg;
    logic [DW-1:0]          den_reg;
    logic [SAMPLE_BITS-1:0] quo_reg;

    always_comb begin
        trial = {in_rem, 1'b0};
        diff = trial - {1'b0, in_den};
        take = (trial >= {1'b0, in_den});
        rem_next = take ? diff[DW-1:0] : trial[DW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg <= in_side;
            rem_reg  <= rem_next;
            den_reg  <= in_den;
            quo_reg  <= {in_quo[SAMPLE_BITS-2:0], take};
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_quo   = quo_reg;

endmodule

### rtl/core/rdw_back.sv
// Back stages: round, saturate, restore sign, output register with skid word.
`timescale 1ns / 1ps

module rdw_back #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    output logic                          en,
    input  logic                          in_valid,
    input  rdw_pkg::rdw_side_t            in_side,
    input  logic [SAMPLE_BITS-1:0]        in_quo,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_sample_out,
    output logic                          m_channel_out,
    output logic                          m_buffer_end_out
);
    import rdw_pkg::*;

    logic [SAMPLE_BITS:0]   rounded;
    logic [SAMPLE_BITS-2:0] mag_next;

    logic                   r_valid_reg;
    rdw_side_t              r_side_reg;
    logic [SAMPLE_BITS-2:0] r_mag_reg;

    logic [SAMPLE_BITS-1:0] inc_sample;
    logic                   inc_valid;

    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_sample_reg;
    logic                   out_channel_reg;
    logic                   out_buffer_end_reg;

    logic                   skid_valid_reg;
    logic [SAMPLE_BITS-1:0] skid_sample_reg;
    logic                   skid_channel_reg;
    logic                   skid_buffer_end_reg;

    assign en = !skid_valid_reg;

    always_comb begin
        rounded = {1'b0, in_quo} + (SAMPLE_BITS + 1)'(1);
        mag_next = rounded[SAMPLE_BITS] ? '1 : rounded[SAMPLE_BITS-1:1];
        inc_sample = r_side_reg.neg ? (~{1'b0, r_mag_reg} + SAMPLE_BITS'(1))
                                    : {1'b0, r_mag_reg};
        inc_valid = en && r_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_valid_reg <= 1'b0;
        end else if (en) begin
            r_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_side_reg <= in_side;
            r_mag_reg  <= mag_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg  <= skid_valid_reg || inc_valid;
            skid_valid_reg <= 1'b0;
        end else if (inc_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // load output from skid, else incoming; on a stall hold incoming in skid
    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_sample_reg     <= skid_sample_reg;
                out_channel_reg    <= skid_channel_reg;
                out_buffer_end_reg <= skid_buffer_end_reg;
            end else begin
                out_sample_reg     <= inc_sample;
                out_channel_reg    <= r_side_reg.channel;
                out_buffer_end_reg <= r_side_reg.buffer_end;
            end
        end else if (inc_valid) begin
            skid_sample_reg     <= inc_sample;
            skid_channel_reg    <= r_side_reg.channel;
            skid_buffer_end_reg <= r_side_reg.buffer_end;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_sample_out     = out_sample_reg;
    assign m_channel_out    = out_channel_reg;
    assign m_buffer_end_out = out_buffer_end_reg;

endmodule

### rtl/core/rdw_checker.sv
// Port-level checks of the rational drive waveshaper, bound to the top level.
`timescale 1ns / 1ps

module rdw_checker #(
    parameter int SAMPLE_BITS = 24
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic signed [SAMPLE_BITS-1:0]  m_sample_out,
    input logic                           m_channel_out,
    input logic                           m_buffer_end_out
);

    localparam logic [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample_out)
            && $stable(m_channel_out) && $stable(m_buffer_end_out))
        else $error("output word changed while stalled");

    a_no_most_neg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_sample_out != MOST_NEG)
        else $error("output carries the most negative code");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input blocked with no output word pending");

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("reset left output valid or input blocked");

endmodule

bind rational_drive_waveshaper rdw_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_rdw_checker (.*);
